// File: rtl/psfd_pkg.sv
// Shared types and constants for the per-source scan and flood detector.
// No dependencies; used by every module in rtl/.
package psfd_pkg;

	localparam int SOURCE_ENTRIES_DEF = 64;
	localparam int PORTS_DEF          = 16;
	localparam int CONNS_DEF          = 32;

	// stored set fill counts are wide enough for a set of 256
	localparam int FILL_W = 9;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_PORT_SCAN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CONN_FLOOD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PKT_FLOOD  = 2'd2;

	localparam logic [4:0]  PORT_SCAN_RST  = 5'd5;
	localparam logic [5:0]  CONN_FLOOD_RST = 6'd15;
	localparam logic [15:0] PKT_FLOOD_RST  = 16'd50;

	localparam logic [3:0] MOD10_LAST = 4'd9;

	typedef struct packed {
		logic [31:0] source_addr;
		logic [31:0] dest_addr;
		logic [7:0]  proto_number;
		logic [15:0] dest_port;
		logic [15:0] frame_length;
	} pkt_t;

	typedef struct packed {
		logic        table_full;
		logic        port_scan_flag;
		logic        conn_flood_flag;
		logic        packet_flood_flag;
		logic        summary_due;
		logic [4:0]  distinct_ports;
		logic [5:0]  distinct_conns;
		logic [31:0] source_packets;
		logic [47:0] source_bytes;
	} rpt_t;

	// per-source record; mod10 tracks pkt % 10 alongside the count
	typedef struct packed {
		logic [31:0]       pkt;
		logic [47:0]       bytes;
		logic [FILL_W-1:0] pfill;
		logic [FILL_W-1:0] cfill;
		logic [3:0]        mod10;
	} stat_t;

	typedef struct packed {
		logic key_we;
		logic stat_we;
		logic port_we;
		logic conn_we;
	} tbl_we_t;

	typedef enum logic [1:0] {
		CMP_KEY,
		CMP_PORT,
		CMP_CONN
	} cmp_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRD,
		ST_SCMP,
		ST_NEW,
		ST_STRD,
		ST_STLD,
		ST_PSTART,
		ST_PRD,
		ST_PCMP,
		ST_PADD,
		ST_CSTART,
		ST_CRD,
		ST_CCMP,
		ST_CADD,
		ST_UPD,
		ST_RES
	} state_t;

endpackage

// File: rtl/per_source_scan_flood_detector_core.sv
// Top level of the per-source scan and flood detector: sequencer, counters, config.
// Depends on psfd_pkg, psfd_cmp, psfd_tables.
//
//  channel | handshake             | payload
//  pkt     | pkt_valid / pkt_stall | pkt (pkt_t): one packet's header fields
//  rpt     | rpt_valid / rpt_stall | rpt (rpt_t): flags and counts, one beat per packet
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data: limit register write
//
// Each packet is a sequential search: the source entries up to the one matched (or
// all entries in use for a new source), then the port and pair sets up to their fills;
// the single shared comparator and the one read port per table make the search serial.
// pkt_stall is low only in idle; a finished report waits in the output register.
// Reset clears the entry fill count and the output valid and loads the default limits; no clearing pass.
module per_source_scan_flood_detector_core import psfd_pkg::*; #(
	parameter int SOURCE_ENTRIES   = SOURCE_ENTRIES_DEF,
	parameter int PORTS_PER_SOURCE = PORTS_DEF,
	parameter int CONNS_PER_SOURCE = CONNS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pkt_valid,
	output logic                 pkt_stall,
	input  pkt_t                 pkt,
	output logic                 rpt_valid,
	input  logic                 rpt_stall,
	output rpt_t                 rpt,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	localparam int SW  = $clog2(SOURCE_ENTRIES);
	localparam int UW  = $clog2(SOURCE_ENTRIES + 1);
	localparam int PAW = $clog2(SOURCE_ENTRIES * PORTS_PER_SOURCE);
	localparam int CAW = $clog2(SOURCE_ENTRIES * CONNS_PER_SOURCE);

	state_t            state_q, state_d;
	pkt_t              in_q;
	logic [UW-1:0]     used_q, idx_q;
	logic [SW-1:0]     e_q;
	logic [FILL_W-1:0] j_q;
	stat_t             st_q;
	rpt_t              res_q, rpt_q;
	logic              rpt_valid_q;
	logic [4:0]        port_lim_q;
	logic [5:0]        conn_lim_q;
	logic [15:0]       pkt_lim_q;

	tbl_we_t           we;
	cmp_sel_t          cmp_sel;
	logic              hit;
	logic              is_tcp_udp;
	logic              tbl_full;
	logic [31:0]       key_rdata;
	stat_t             stat_rdata;
	logic [15:0]       port_rdata;
	logic [47:0]       conn_rdata;
	logic [FILL_W-1:0] port_idx, conn_idx;
	logic [PAW-1:0]    port_addr;
	logic [CAW-1:0]    conn_addr;
	logic [48:0]       byte_sum;
	rpt_t              res_d;

	assign is_tcp_udp = (in_q.proto_number == PROTO_TCP) || (in_q.proto_number == PROTO_UDP);
	assign tbl_full   = (used_q == UW'(SOURCE_ENTRIES));
	assign pkt_stall  = (state_q != ST_IDLE);
	assign cfg_ready  = 1'b1;
	assign rpt_valid  = rpt_valid_q;
	assign rpt        = rpt_q;

	assign port_idx  = (state_q == ST_PADD) ? st_q.pfill : j_q;
	assign conn_idx  = (state_q == ST_CADD) ? st_q.cfill : j_q;
	assign port_addr = PAW'(e_q) * PAW'(PORTS_PER_SOURCE) + PAW'(port_idx);
	assign conn_addr = CAW'(e_q) * CAW'(CONNS_PER_SOURCE) + CAW'(conn_idx);
	assign byte_sum  = {1'b0, st_q.bytes} + {33'd0, in_q.frame_length};

	psfd_tables #(
		.SOURCE_ENTRIES(SOURCE_ENTRIES),
		.PORTS(PORTS_PER_SOURCE),
		.CONNS(CONNS_PER_SOURCE)
	) u_tables (
		.clk       (clk),
		.we        (we),
		.key_raddr (idx_q[SW-1:0]),
		.key_waddr (used_q[SW-1:0]),
		.key_wdata (in_q.source_addr),
		.key_rdata (key_rdata),
		.stat_raddr(e_q),
		.stat_waddr(e_q),
		.stat_wdata(st_q),
		.stat_rdata(stat_rdata),
		.port_addr (port_addr),
		.port_wdata(in_q.dest_port),
		.port_rdata(port_rdata),
		.conn_addr (conn_addr),
		.conn_wdata({in_q.dest_addr, in_q.dest_port}),
		.conn_rdata(conn_rdata)
	);

	psfd_cmp u_cmp (
		.sel       (cmp_sel),
		.key_rdata (key_rdata),
		.port_rdata(port_rdata),
		.conn_rdata(conn_rdata),
		.item      (in_q),
		.hit       (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		we      = '0;
		cmp_sel = CMP_KEY;
		unique case (state_q)
			ST_IDLE: begin
				if (pkt_valid) state_d = (used_q == '0) ? ST_NEW : ST_SRD;
			end
			ST_SRD: state_d = ST_SCMP;
			ST_SCMP: begin
				cmp_sel = CMP_KEY;
				if (hit) state_d = ST_STRD;
				else if ((idx_q + UW'(1)) == used_q) state_d = ST_NEW;
				else state_d = ST_SRD;
			end
			ST_NEW: begin
				if (tbl_full) begin
					state_d = ST_RES;
				end else begin
					we.key_we = 1'b1;
					state_d   = is_tcp_udp ? ST_PSTART : ST_UPD;
				end
			end
			ST_STRD: state_d = ST_STLD;
			ST_STLD: state_d = is_tcp_udp ? ST_PSTART : ST_UPD;
			ST_PSTART: state_d = (st_q.pfill == '0) ? ST_PADD : ST_PRD;
			ST_PRD: state_d = ST_PCMP;
			ST_PCMP: begin
				cmp_sel = CMP_PORT;
				if (hit) state_d = ST_CSTART;
				else if ((j_q + FILL_W'(1)) == st_q.pfill) state_d = ST_PADD;
				else state_d = ST_PRD;
			end
			ST_PADD: begin
				we.port_we = (st_q.pfill < FILL_W'(PORTS_PER_SOURCE));
				state_d    = ST_CSTART;
			end
			ST_CSTART: state_d = (st_q.cfill == '0) ? ST_CADD : ST_CRD;
			ST_CRD: state_d = ST_CCMP;
			ST_CCMP: begin
				cmp_sel = CMP_CONN;
				if (hit) state_d = ST_UPD;
				else if ((j_q + FILL_W'(1)) == st_q.cfill) state_d = ST_CADD;
				else state_d = ST_CRD;
			end
			ST_CADD: begin
				we.conn_we = (st_q.cfill < FILL_W'(CONNS_PER_SOURCE));
				state_d    = ST_UPD;
			end
			ST_UPD: state_d = ST_RES;
			ST_RES: begin
				// table-full reports skip the record write-back
				we.stat_we = !res_q.table_full;
				if (!rpt_valid_q || !rpt_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// report fields straight from the settled record; table-full keeps them zero
	always_comb begin
		res_d = res_q;
		if (!res_q.table_full) begin
			res_d.port_scan_flag    = (st_q.pfill >= FILL_W'(port_lim_q));
			res_d.conn_flood_flag   = (st_q.cfill >= FILL_W'(conn_lim_q));
			res_d.packet_flood_flag = (st_q.pkt >= {16'd0, pkt_lim_q});
			res_d.summary_due       = (st_q.mod10 == 4'd0);
			res_d.distinct_ports    = st_q.pfill[4:0];
			res_d.distinct_conns    = st_q.cfill[5:0];
			res_d.source_packets    = st_q.pkt;
			res_d.source_bytes      = st_q.bytes;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			rpt_valid_q <= 1'b0;
			port_lim_q  <= PORT_SCAN_RST;
			conn_lim_q  <= CONN_FLOOD_RST;
			pkt_lim_q   <= PKT_FLOOD_RST;
		end else begin
			if (state_q == ST_NEW && !tbl_full) used_q <= used_q + UW'(1);
			if (state_q == ST_RES && (!rpt_valid_q || !rpt_stall)) rpt_valid_q <= 1'b1;
			else if (!rpt_stall) rpt_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_PORT_SCAN:  port_lim_q <= cfg_data[4:0];
					CFG_CONN_FLOOD: conn_lim_q <= cfg_data[5:0];
					CFG_PKT_FLOOD:  pkt_lim_q  <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (state_q == ST_RES && (!rpt_valid_q || !rpt_stall)) rpt_q <= res_d;
		case (state_q)
			ST_IDLE: begin
				in_q  <= pkt;
				idx_q <= '0;
				res_q <= '0;
			end
			ST_SCMP: begin
				if (hit) e_q <= idx_q[SW-1:0];
				else idx_q <= idx_q + UW'(1);
			end
			ST_NEW: begin
				e_q  <= used_q[SW-1:0];
				st_q <= '0;
				if (tbl_full) res_q.table_full <= 1'b1;
			end
			ST_STLD: st_q <= stat_rdata;
			ST_PSTART, ST_CSTART: j_q <= '0;
			ST_PCMP, ST_CCMP: j_q <= j_q + FILL_W'(1);
			ST_PADD: begin
				if (we.port_we) st_q.pfill <= st_q.pfill + FILL_W'(1);
			end
			ST_CADD: begin
				if (we.conn_we) st_q.cfill <= st_q.cfill + FILL_W'(1);
			end
			ST_UPD: begin
				if (st_q.pkt != '1) begin
					st_q.pkt   <= st_q.pkt + 32'd1;
					st_q.mod10 <= (st_q.mod10 == MOD10_LAST) ? 4'd0 : st_q.mod10 + 4'd1;
				end
				st_q.bytes <= byte_sum[48] ? '1 : byte_sum[47:0];
			end
			default: ;
		endcase
	end

	// st_q is final on entry to ST_RES, so the report can be copied as soon as the output register is free

`ifndef SYNTHESIS
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UW'(SOURCE_ENTRIES)) else $error("entry count past table size");
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCMP) |-> (idx_q < used_q)) else $error("source scan past fill");
	a_port_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PCMP) |-> (j_q < st_q.pfill)) else $error("port scan past fill");
	a_rpt_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RES && !rpt_stall) |=> rpt_valid) else $error("report beat lost");
`endif

endmodule

// File: rtl/psfd_cmp.sv
// Shared equality compare unit: one comparator serves the source, port and pair searches.
// Depends on psfd_pkg.
module psfd_cmp import psfd_pkg::*; (
	input  cmp_sel_t    sel,
	input  logic [31:0] key_rdata,
	input  logic [15:0] port_rdata,
	input  logic [47:0] conn_rdata,
	input  pkt_t        item,
	output logic        hit
);

	logic [47:0] a;
	logic [47:0] b;

	always_comb begin
		unique case (sel)
			CMP_KEY: begin
				a = {16'd0, key_rdata};
				b = {16'd0, item.source_addr};
			end
			CMP_PORT: begin
				a = {32'd0, port_rdata};
				b = {32'd0, item.dest_port};
			end
			CMP_CONN: begin
				a = conn_rdata;
				b = {item.dest_addr, item.dest_port};
			end
			default: begin
				a = '0;
				b = '1;
			end
		endcase
	end

	assign hit = (a == b);

endmodule

// File: rtl/psfd_tables.sv
// Source key table, per-source record table, port sets and pair sets.
// Registered reads, one write each. Depends on psfd_pkg.
module psfd_tables import psfd_pkg::*; #(
	parameter int SOURCE_ENTRIES = SOURCE_ENTRIES_DEF,
	parameter int PORTS          = PORTS_DEF,
	parameter int CONNS          = CONNS_DEF,
	localparam int SW  = $clog2(SOURCE_ENTRIES),
	localparam int PAW = $clog2(SOURCE_ENTRIES * PORTS),
	localparam int CAW = $clog2(SOURCE_ENTRIES * CONNS)
) (
	input  logic           clk,
	input  tbl_we_t        we,
	input  logic [SW-1:0]  key_raddr,
	input  logic [SW-1:0]  key_waddr,
	input  logic [31:0]    key_wdata,
	output logic [31:0]    key_rdata,
	input  logic [SW-1:0]  stat_raddr,
	input  logic [SW-1:0]  stat_waddr,
	input  stat_t          stat_wdata,
	output stat_t          stat_rdata,
	input  logic [PAW-1:0] port_addr,
	input  logic [15:0]    port_wdata,
	output logic [15:0]    port_rdata,
	input  logic [CAW-1:0] conn_addr,
	input  logic [47:0]    conn_wdata,
	output logic [47:0]    conn_rdata
);

	logic [31:0] key_mem  [SOURCE_ENTRIES];
	stat_t       stat_mem [SOURCE_ENTRIES];
	logic [15:0] port_mem [SOURCE_ENTRIES * PORTS];
	logic [47:0] conn_mem [SOURCE_ENTRIES * CONNS];

	always_ff @(posedge clk) begin
		if (we.key_we) key_mem[key_waddr] <= key_wdata;
		key_rdata <= key_mem[key_raddr];
	end

	always_ff @(posedge clk) begin
		if (we.stat_we) stat_mem[stat_waddr] <= stat_wdata;
		stat_rdata <= stat_mem[stat_raddr];
	end

	always_ff @(posedge clk) begin
		if (we.port_we) port_mem[port_addr] <= port_wdata;
		port_rdata <= port_mem[port_addr];
	end

	always_ff @(posedge clk) begin
		if (we.conn_we) conn_mem[conn_addr] <= conn_wdata;
		conn_rdata <= conn_mem[conn_addr];
	end

endmodule
